>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is held.
`define MIUT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define MIUT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/miut_pkg.sv
package miut_pkg;

  localparam int unsigned CHANNELS_DEF = 32;
  localparam int unsigned BANKS_DEF    = 128;
  localparam int unsigned INSTRUMENTS  = 128;

  typedef enum logic [2:0] {
    CMD_NOTE_ON    = 3'd0,
    CMD_PROGRAM    = 3'd1,
    CMD_BANK_LSB   = 3'd2,
    CMD_BANK_MSB   = 3'd3,
    CMD_CHAN_RESET = 3'd4,
    CMD_READ_MEL   = 3'd5,
    CMD_READ_DRUM  = 3'd6
  } miut_cmd_e;

  typedef enum logic {
    CFG_DRUM_MASK = 1'b0,
    CFG_XG_MODE   = 1'b1
  } miut_cfg_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RECORD,
    OP_READ
  } miut_op_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  midi_channel;
    logic [6:0]  data_value;
    logic [6:0]  velocity;
    logic [30:0] event_time;
    logic [6:0]  query_bank;
  } miut_in_t;

  typedef struct packed {
    logic        entry_used;
    logic [30:0] first_time;
    logic [31:0] note_count;
  } miut_out_t;

  // One table entry as it is held in memory. An all-zero entry is unused.
  typedef struct packed {
    logic        used;
    logic [30:0] first;
    logic [31:0] count;
  } miut_entry_t;

  // Table access handed from the channel unit to the table engine.
  typedef struct packed {
    miut_op_e    op;
    logic        drum;
    logic [13:0] loc;    // bank in the upper seven bits, instrument below
    logic [30:0] stamp;
  } miut_req_t;

endpackage

>>> hw/rtl/miut_ram.sv
module miut_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/miut_chan.sv
module miut_chan import miut_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  miut_in_t    item_i,
  input  logic [31:0] drum_mask_i,
  input  logic        xg_mode_i,
  output logic        req_valid_o,
  output miut_req_t   req_o
);

  // The channel field has five bits, so no more than 32 channels can be addressed.
  localparam int unsigned ChanDepth = (CHANNELS < 32) ? CHANNELS : 32;
  localparam int unsigned IdxW      = (ChanDepth > 1) ? $clog2(ChanDepth) : 1;

  logic [6:0] bank_q [ChanDepth];
  logic [6:0] prog_q [ChanDepth];
  logic [6:0] lsb_q  [ChanDepth];
  logic [6:0] msb_q  [ChanDepth];

  logic [IdxW-1:0] idx;
  logic            valid_ch;
  logic            is_drum;

  assign idx      = item_i.midi_channel[IdxW-1:0];
  assign valid_ch = ({1'b0, item_i.midi_channel} < 6'(ChanDepth));
  assign is_drum  = drum_mask_i[item_i.midi_channel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChanDepth; i++) begin
        bank_q[i] <= '0;
        prog_q[i] <= '0;
        lsb_q[i]  <= '0;
        msb_q[i]  <= '0;
      end
    end else if (accept_i) begin
      unique case (item_i.command)
        CMD_PROGRAM: begin
          if (valid_ch) begin
            if (is_drum) begin
              bank_q[idx] <= item_i.data_value;
            end else begin
              bank_q[idx] <= xg_mode_i ? lsb_q[idx] : msb_q[idx];
              prog_q[idx] <= item_i.data_value;
            end
          end
        end
        CMD_BANK_LSB: begin
          if (valid_ch) begin
            lsb_q[idx] <= item_i.data_value;
          end
        end
        CMD_BANK_MSB: begin
          if (valid_ch) begin
            msb_q[idx] <= item_i.data_value;
          end
        end
        CMD_CHAN_RESET: begin
          for (int i = 0; i < ChanDepth; i++) begin
            bank_q[i] <= '0;
            prog_q[i] <= '0;
            lsb_q[i]  <= '0;
            msb_q[i]  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Note-ons with a nonzero velocity on a channel in range, and reads, turn into a table access.
  always_comb begin
    req_o.op    = OP_NONE;
    req_o.drum  = 1'b0;
    req_o.loc   = {item_i.query_bank, item_i.data_value};
    req_o.stamp = item_i.event_time;
    unique case (item_i.command)
      CMD_NOTE_ON: begin
        if (valid_ch && (item_i.velocity != '0)) begin
          req_o.op   = OP_RECORD;
          req_o.drum = is_drum;
          req_o.loc  = {bank_q[idx], is_drum ? item_i.data_value : prog_q[idx]};
        end
      end
      CMD_READ_MEL: begin
        req_o.op = OP_READ;
      end
      CMD_READ_DRUM: begin
        req_o.op   = OP_READ;
        req_o.drum = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign req_valid_o = accept_i && (req_o.op != OP_NONE);

endmodule

>>> hw/rtl/miut_table.sv
module miut_table import miut_pkg::*; #(
  parameter int unsigned BANKS = BANKS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  miut_req_t req_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output miut_out_t res_o
);

  localparam int unsigned TblDepth = BANKS * INSTRUMENTS;
  localparam int unsigned AddrW    = $clog2(TblDepth);
  localparam int unsigned EntryW   = $bits(miut_entry_t);

  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             stage_valid_q;
  logic             stage_hit_q;
  miut_req_t        stage_q;
  logic             res_valid_q;
  miut_out_t        res_q, res_d;

  logic             req_hit;
  logic [AddrW-1:0] req_addr;
  logic [AddrW-1:0] stage_addr;
  miut_entry_t      rd_mel, rd_drum, old_entry, new_entry;
  logic             we_mel, we_drum;
  logic [AddrW-1:0] waddr;
  miut_entry_t      wdata;

  // A bank within range keeps bank * 128 + instrument below the depth.
  assign req_hit    = ({1'b0, req_i.loc[13:7]} < 8'(BANKS));
  assign req_addr   = AddrW'(req_i.loc);
  assign stage_addr = AddrW'(stage_q.loc);

  miut_ram #(.DEPTH(TblDepth), .WIDTH(EntryW)) u_mel_ram (
    .clk_i   (clk_i),
    .we_i    (we_mel),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (req_valid_i),
    .raddr_i (req_addr),
    .rdata_o (rd_mel)
  );

  miut_ram #(.DEPTH(TblDepth), .WIDTH(EntryW)) u_drum_ram (
    .clk_i   (clk_i),
    .we_i    (we_drum),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (req_valid_i),
    .raddr_i (req_addr),
    .rdata_o (rd_drum)
  );

  assign old_entry = stage_q.drum ? rd_drum : rd_mel;

  always_comb begin
    new_entry.used  = 1'b1;
    new_entry.first = old_entry.used ? old_entry.first : stage_q.stamp;
    new_entry.count = (old_entry.count == '1) ? old_entry.count : old_entry.count + 32'd1;
  end

  always_comb begin
    we_mel  = 1'b0;
    we_drum = 1'b0;
    waddr   = stage_addr;
    wdata   = new_entry;
    if (clr_q) begin
      we_mel  = 1'b1;
      we_drum = 1'b1;
      waddr   = clr_addr_q;
      wdata   = '0;
    end else if (stage_valid_q && stage_hit_q && (stage_q.op == OP_RECORD)) begin
      we_mel  = !stage_q.drum;
      we_drum = stage_q.drum;
    end
  end

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == AddrW'(TblDepth - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AddrW'(1);
      end
    end
  end

  always_comb begin
    res_d = '0;
    if (stage_hit_q) begin
      res_d.entry_used = old_entry.used;
      res_d.first_time = old_entry.first;
      res_d.note_count = old_entry.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q         <= 1'b1;
      clr_addr_q    <= '0;
      stage_valid_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      clr_q         <= clr_d;
      clr_addr_q    <= clr_addr_d;
      stage_valid_q <= req_valid_i;
      res_valid_q   <= stage_valid_q && (stage_q.op == OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      stage_q     <= req_i;
      stage_hit_q <= req_hit;
    end
    if (stage_valid_q) begin
      res_q <= res_d;
    end
  end

  assign busy_o      = clr_q || stage_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/midi_instrument_usage_tracker_top.sv
// Channel        | Direction | Handshake                     | Payload
// item           | in        | start high while busy is low  | item_i (miut_in_t)
// result         | out       | result_valid_o, one cycle     | result_o (miut_out_t)
// configuration  | in        | cfg_valid_i and cfg_ready_o   | cfg_index_i, cfg_data_i
//
// Bank, program and controller commands, channel resets, ignored note-ons and the unused
// command code leave busy low, so the next item may start straight away.
// Recorded note-ons and reads hold busy high for the read-modify-write of the table
// memory, whose read data is registered and arrives in the cycle after the address.
// A read's result is shown in the first cycle in which busy is low again, for that one
// cycle only, and the receiver cannot stall it; the next item may be accepted in that cycle.
// After reset the block clears every entry of both table memories with busy held high;
// configuration writes are taken only while busy and start are both low.
module midi_instrument_usage_tracker_top import miut_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned BANKS    = BANKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  miut_in_t    item_i,
  output logic        result_valid_o,
  output miut_out_t   result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] drum_mask_q;
  logic        xg_mode_q;
  logic        accept;
  logic        req_valid;
  miut_req_t   req;

  // An item is taken whenever the table engine is neither clearing nor finishing an access.
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy && !start;

  // The configuration registers are only written while the block is idle, so no item sees
  // a half-changed setting.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drum_mask_q <= 32'h0000_0200;
      xg_mode_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (miut_cfg_e'(cfg_index_i))
        CFG_DRUM_MASK: drum_mask_q <= cfg_data_i;
        CFG_XG_MODE:   xg_mode_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The channel unit keeps the per-channel bank and program state and turns note-ons and
  // reads into table accesses.
  miut_chan #(.CHANNELS(CHANNELS)) u_chan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .drum_mask_i (drum_mask_q),
    .xg_mode_i   (xg_mode_q),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  // The table engine owns the melodic and drum memories and their clearing sweep.
  miut_table #(.BANKS(BANKS)) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .busy_o      (busy),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

>>> hw/rtl/miut_checker.sv
`include "assert_macros.svh"

module miut_checker import miut_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input miut_in_t    item_i,
  input logic        result_valid_o,
  input miut_out_t   result_o
);

  logic read_taken;
  logic unused_res;
  logic res_time_zero;

  // A read command accepted at this edge.
  assign read_taken    = start && !busy &&
                         (item_i.command == CMD_READ_MEL || item_i.command == CMD_READ_DRUM);
  assign unused_res    = result_valid_o && !result_o.entry_used;
  assign res_time_zero = (result_o.first_time == '0);

  `MIUT_ASSERT(a_result_one_cycle, result_valid_o |=> !result_valid_o, "result strobe held")

  `MIUT_ASSERT(a_result_follows_read, result_valid_o |-> $past(read_taken, 2), "result without a read")

  `MIUT_ASSERT(a_read_busy, read_taken |=> busy, "read did not hold busy")

  `MIUT_ASSERT(a_unused_zero_time, unused_res |-> res_time_zero, "unused entry with a time")

endmodule

bind midi_instrument_usage_tracker_top miut_checker u_miut_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

>>> tb/tb.sv
module tb;
  import miut_pkg::*;

  // Command code 7 is left unused by the block and must be ignored.
  localparam logic [2:0]  CMD_UNUSED   = 3'd7;
  localparam int unsigned TABLE_SIZE   = BANKS_DEF * INSTRUMENTS;
  localparam logic [31:0] NEVER_PLAYED = 32'hFFFF_FFFF;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_EVENTS = 300;
  // The limit covers the clearing sweep after reset and then, for every item, its busy time
  // plus a random gap on the sender side, so this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One row of the opening script. Where want_fixed is set, the expected read result
  // is written into the row by hand instead of being taken from the tracker model.
  typedef struct {
    miut_in_t  ev;
    bit        want_fixed;
    miut_out_t want;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  miut_in_t    item_i;
  logic        result_valid_o;
  miut_out_t   result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  // Side-band of the item on the ports: a hand-written expectation, if any.
  bit          row_fixed;
  miut_out_t   row_out;

  // Handshake flags, sampled at the rising edge and looked at by the driver at the
  // following falling edge.
  bit          item_taken_q;
  bit          cfg_taken_q;

  // Model of the tracker: configuration, per-channel state and the two usage tables.
  logic [31:0] drum_mask_m;
  logic        xg_mode_m;
  logic [6:0]  bank_of   [CHANNELS_DEF];
  logic [6:0]  prog_of   [CHANNELS_DEF];
  logic [6:0]  lsb_of    [CHANNELS_DEF];
  logic [6:0]  msb_of    [CHANNELS_DEF];
  logic [31:0] mel_first [TABLE_SIZE];
  logic [31:0] mel_count [TABLE_SIZE];
  logic [31:0] drm_first [TABLE_SIZE];
  logic [31:0] drm_count [TABLE_SIZE];

  miut_out_t   pending_reads[$];
  script_row_t opening_events[$];

  int unsigned mismatch_count;
  int unsigned reads_checked;
  int unsigned events_taken;
  int unsigned settings_seen;
  int unsigned cycle_count;
  bit          sender_idles;

  midi_instrument_usage_tracker_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Clock with a period of two time units.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bank, program and bank select registers of every channel go back to zero.
  function automatic void clear_channel_state();
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      bank_of[c] = '0;
      prog_of[c] = '0;
      lsb_of[c]  = '0;
      msb_of[c]  = '0;
    end
  endfunction

  // A note-on that counts: the first one stamps its time, and the count saturates.
  function automatic void note_hit(input bit drum, input logic [6:0] bank,
                                   input logic [6:0] inst, input logic [30:0] stamp);
    logic [13:0] slot;
    slot = {bank, inst};
    if (bank >= BANKS_DEF) return;
    if (drum) begin
      if (drm_first[slot] == NEVER_PLAYED) drm_first[slot] = {1'b0, stamp};
      if (drm_count[slot] != 32'hFFFF_FFFF) drm_count[slot]++;
    end else begin
      if (mel_first[slot] == NEVER_PLAYED) mel_first[slot] = {1'b0, stamp};
      if (mel_count[slot] != 32'hFFFF_FFFF) mel_count[slot]++;
    end
  endfunction

  // Applies one accepted event to the model; for the two read commands it also gives
  // the entry that the block has to return.
  function automatic void track_event(input miut_in_t ev, output bit is_read,
                                      output miut_out_t entry);
    logic [13:0] slot;
    logic [31:0] first_w;
    logic [31:0] count_w;
    bit          drum_ch;
    is_read = 1'b0;
    entry   = '0;
    slot    = {ev.query_bank, ev.data_value};
    drum_ch = drum_mask_m[ev.midi_channel];
    case (ev.command)
      CMD_NOTE_ON: begin
        if (ev.velocity != '0) begin
          if (drum_ch) note_hit(1'b1, bank_of[ev.midi_channel], ev.data_value, ev.event_time);
          else note_hit(1'b0, bank_of[ev.midi_channel], prog_of[ev.midi_channel],
                        ev.event_time);
        end
      end
      CMD_PROGRAM: begin
        if (drum_ch) begin
          bank_of[ev.midi_channel] = ev.data_value;
        end else begin
          bank_of[ev.midi_channel] = xg_mode_m ? lsb_of[ev.midi_channel]
                                               : msb_of[ev.midi_channel];
          prog_of[ev.midi_channel] = ev.data_value;
        end
      end
      CMD_BANK_LSB:   lsb_of[ev.midi_channel] = ev.data_value;
      CMD_BANK_MSB:   msb_of[ev.midi_channel] = ev.data_value;
      CMD_CHAN_RESET: clear_channel_state();
      CMD_READ_MEL, CMD_READ_DRUM: begin
        is_read = 1'b1;
        first_w = (ev.command == CMD_READ_DRUM) ? drm_first[slot] : mel_first[slot];
        count_w = (ev.command == CMD_READ_DRUM) ? drm_count[slot] : mel_count[slot];
        if (ev.query_bank < BANKS_DEF) begin
          entry.entry_used = (first_w != NEVER_PLAYED);
          entry.first_time = entry.entry_used ? first_w[30:0] : '0;
          entry.note_count = count_w;
        end
      end
      default: ;
    endcase
  endfunction

  // Observation at the rising edge: configuration writes and accepted items update the
  // model, and every result strobe is held against the oldest outstanding read.
  always @(posedge clk_i) begin
    bit        is_read;
    miut_out_t entry;
    miut_out_t want;
    item_taken_q <= rst_ni && start && !busy;
    cfg_taken_q  <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_DRUM_MASK) drum_mask_m = cfg_data_i;
      else xg_mode_m = cfg_data_i[0];
    end
    if (rst_ni && start && !busy) begin
      track_event(item_i, is_read, entry);
      events_taken++;
      if (is_read) pending_reads.push_back(row_fixed ? row_out : entry);
    end
    if (rst_ni && result_valid_o) begin
      if (pending_reads.size() == 0) begin
        $error("result strobe with no read outstanding");
        mismatch_count++;
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (result_o.entry_used !== want.entry_used) begin
          $error("entry_used: expected %0d, got %0d", want.entry_used, result_o.entry_used);
          mismatch_count++;
        end
        if (result_o.first_time !== want.first_time) begin
          $error("first_time: expected %0d, got %0d", want.first_time, result_o.first_time);
          mismatch_count++;
        end
        if (result_o.note_count !== want.note_count) begin
          $error("note_count: expected %0d, got %0d", want.note_count, result_o.note_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic miut_in_t make_event(input logic [2:0] cmd, input logic [4:0] chan,
                                          input logic [6:0] data, input logic [6:0] vel,
                                          input logic [30:0] stamp, input logic [6:0] qbank);
    miut_in_t ev;
    ev.command      = cmd;
    ev.midi_channel = chan;
    ev.data_value   = data;
    ev.velocity     = vel;
    ev.event_time   = stamp;
    ev.query_bank   = qbank;
    return ev;
  endfunction

  task automatic add_row(input miut_in_t ev, input bit fixed, input miut_out_t want);
    script_row_t row;
    row.ev         = ev;
    row.want_fixed = fixed;
    row.want       = want;
    opening_events.push_back(row);
  endtask

  // Small pools of banks, instruments and channels make note-ons and reads land on the
  // same table entries; the rest of the time any value may turn up.
  function automatic logic [6:0] pick_bank();
    case ($urandom_range(0, 7))
      0, 1:    return 7'd0;
      2:       return 7'd1;
      3:       return 7'd5;
      4, 5:    return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [6:0] pick_instrument();
    case ($urandom_range(0, 7))
      0, 1:    return 7'd0;
      2:       return 7'd1;
      3:       return 7'd60;
      4, 5:    return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [4:0] pick_channel();
    case ($urandom_range(0, 9))
      0, 1:    return 5'd0;
      2:       return 5'd1;
      3, 4:    return 5'd9;
      5:       return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // Random event, weighted towards note-ons and reads so that table entries are both
  // built up and looked at. Fields a command does not use are still random.
  function automatic miut_in_t random_event();
    miut_in_t    ev;
    int unsigned pick;
    pick            = $urandom_range(0, 99);
    ev.midi_channel = pick_channel();
    ev.data_value   = pick_instrument();
    ev.velocity     = ($urandom_range(0, 99) < 15) ? 7'd0 : 7'($urandom_range(1, 127));
    ev.event_time   = 31'($urandom);
    ev.query_bank   = pick_bank();
    if (pick < 35) begin
      ev.command = CMD_NOTE_ON;
    end else if (pick < 47) begin
      ev.command = CMD_PROGRAM;
    end else if (pick < 55) begin
      ev.command    = CMD_BANK_LSB;
      ev.data_value = pick_bank();
    end else if (pick < 63) begin
      ev.command    = CMD_BANK_MSB;
      ev.data_value = pick_bank();
    end else if (pick < 65) begin
      ev.command = CMD_CHAN_RESET;
    end else if (pick < 80) begin
      ev.command = CMD_READ_MEL;
    end else if (pick < 95) begin
      ev.command = CMD_READ_DRUM;
    end else begin
      ev.command = CMD_UNUSED;
    end
    return ev;
  endfunction

  // The sender leaves start low for a random number of cycles, unless idling is off.
  task automatic hold_off();
    while (sender_idles && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Presents one item and returns at the falling edge after it was accepted, with start
  // still high, so that the next item may follow without a gap.
  task automatic send_event(input miut_in_t ev, input bit fixed, input miut_out_t want);
    hold_off();
    start     <= 1'b1;
    item_i    <= ev;
    row_fixed <= fixed;
    row_out   <= want;
    do @(negedge clk_i); while (!item_taken_q);
  endtask

  // Stops sending and waits until every outstanding read has returned, then lets the
  // block finish any note-on still in its read-modify-write update.
  task automatic drain();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes both registers back to back over the configuration channel.
  task automatic apply_setting(input logic [31:0] mask, input logic xg);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_DRUM_MASK;
    cfg_data_i  <= mask;
    do @(negedge clk_i); while (!cfg_taken_q);
    cfg_index_i <= CFG_XG_MODE;
    cfg_data_i  <= {31'd0, xg};
    do @(negedge clk_i); while (!cfg_taken_q);
    cfg_valid_i <= 1'b0;
    settings_seen++;
  endtask

  initial begin
    miut_out_t none;
    none        = '0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    row_fixed   = 1'b0;
    row_out     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DRUM_MASK;
    cfg_data_i  = '0;
    sender_idles = 1'b1;
    settings_seen = 1;

    // Model state after reset: channel 9 is the only drum channel, banks come from MSB,
    // and every table entry is marked as never played.
    drum_mask_m = 32'h0000_0200;
    xg_mode_m   = 1'b0;
    clear_channel_state();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      mel_first[i] = NEVER_PLAYED;
      drm_first[i] = NEVER_PLAYED;
      mel_count[i] = '0;
      drm_count[i] = '0;
    end

    // Opening script. Channel 0 is melodic and channel 9 is a drum channel here.
    // Straight after reset every entry reads back as unused, at both ends of the table.
    add_row(make_event(CMD_READ_MEL, 5'd0, 7'd0, 7'd0, 31'd0, 7'd0), 1'b1, none);
    add_row(make_event(CMD_READ_DRUM, 5'd31, 7'd127, 7'd127, 31'h7FFF_FFFF, 7'd127),
            1'b1, none);
    // Bank select MSB and LSB, then a program change: without XG the MSB wins.
    add_row(make_event(CMD_BANK_MSB, 5'd0, 7'd5, 7'd0, 31'd0, 7'd0), 1'b0, none);
    add_row(make_event(CMD_BANK_LSB, 5'd0, 7'd9, 7'd0, 31'd0, 7'd0), 1'b0, none);
    add_row(make_event(CMD_PROGRAM, 5'd0, 7'd127, 7'd0, 31'd0, 7'd0), 1'b0, none);
    // The first note-on stamps the latest possible time; a zero velocity is ignored and
    // a later note-on only counts.
    add_row(make_event(CMD_NOTE_ON, 5'd0, 7'd64, 7'd127, 31'h7FFF_FFFF, 7'd0), 1'b0, none);
    add_row(make_event(CMD_NOTE_ON, 5'd0, 7'd64, 7'd0, 31'd3, 7'd0), 1'b0, none);
    add_row(make_event(CMD_NOTE_ON, 5'd0, 7'd0, 7'd1, 31'd0, 7'd0), 1'b0, none);
    add_row(make_event(CMD_READ_MEL, 5'd0, 7'd127, 7'd0, 31'd0, 7'd5), 1'b1,
            '{entry_used: 1'b1, first_time: 31'h7FFF_FFFF, note_count: 32'd2});
    add_row(make_event(CMD_READ_MEL, 5'd0, 7'd127, 7'd0, 31'd0, 7'd9), 1'b1, none);
    // A drum channel takes its bank straight from the program change, and the note
    // number is the instrument.
    add_row(make_event(CMD_PROGRAM, 5'd9, 7'd127, 7'd0, 31'd0, 7'd0), 1'b0, none);
    add_row(make_event(CMD_NOTE_ON, 5'd9, 7'd0, 7'd64, 31'd1234, 7'd0), 1'b0, none);
    add_row(make_event(CMD_READ_DRUM, 5'd9, 7'd0, 7'd0, 31'd0, 7'd127), 1'b1,
            '{entry_used: 1'b1, first_time: 31'd1234, note_count: 32'd1});
    add_row(make_event(CMD_READ_MEL, 5'd9, 7'd0, 7'd0, 31'd0, 7'd127), 1'b0, none);
    // A channel reset on any channel clears the state of all of them, not the tables.
    add_row(make_event(CMD_CHAN_RESET, 5'd17, 7'd0, 7'd0, 31'd0, 7'd0), 1'b0, none);
    add_row(make_event(CMD_NOTE_ON, 5'd0, 7'd12, 7'd5, 31'd99, 7'd0), 1'b0, none);
    add_row(make_event(CMD_NOTE_ON, 5'd9, 7'd35, 7'd100, 31'd200, 7'd0), 1'b0, none);
    add_row(make_event(CMD_READ_MEL, 5'd0, 7'd0, 7'd0, 31'd0, 7'd0), 1'b1,
            '{entry_used: 1'b1, first_time: 31'd99, note_count: 32'd1});
    add_row(make_event(CMD_READ_DRUM, 5'd0, 7'd35, 7'd0, 31'd0, 7'd0), 1'b1,
            '{entry_used: 1'b1, first_time: 31'd200, note_count: 32'd1});
    // The unused command code with every field at its top value does nothing.
    add_row(make_event(CMD_UNUSED, 5'd31, 7'd127, 7'd127, 31'h7FFF_FFFF, 7'd127), 1'b0, none);
    // The highest channel and the highest bank.
    add_row(make_event(CMD_BANK_MSB, 5'd31, 7'd127, 7'd0, 31'd0, 7'd0), 1'b0, none);
    add_row(make_event(CMD_PROGRAM, 5'd31, 7'd1, 7'd0, 31'd0, 7'd0), 1'b0, none);
    add_row(make_event(CMD_NOTE_ON, 5'd31, 7'd99, 7'd127, 31'd5, 7'd0), 1'b0, none);
    add_row(make_event(CMD_READ_MEL, 5'd31, 7'd1, 7'd0, 31'd0, 7'd127), 1'b0, none);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The block sweeps its tables after reset with busy high; the first item simply
    // waits for it.
    foreach (opening_events[i]) begin
      send_event(opening_events[i].ev, opening_events[i].want_fixed, opening_events[i].want);
    end

    // Random phases, each under its own register setting. The setting is only changed
    // once the block has gone quiet. Phase 2 runs with no sender gaps at all, and in
    // phase 3 the sender stops half way until every read has come back.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1:       apply_setting(32'h0000_0000, 1'b1);
          2:       apply_setting(32'hFFFF_FFFF, 1'b0);
          3:       apply_setting(32'h0000_0200, 1'b1);
          4:       apply_setting($urandom, 1'b0);
          default: apply_setting($urandom, 1'($urandom_range(0, 1)));
        endcase
      end
      sender_idles = (phase != 2);
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        if (phase == 3 && n == PHASE_EVENTS / 2) drain();
        send_event(random_event(), 1'b0, none);
      end
    end

    drain();
    $display("Covered %0d events and %0d checked reads under %0d register settings,",
             events_taken, reads_checked, settings_seen);
    $display("from all-melodic to all-drum channel masks, in both bank select modes.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
